/* rtl/tdpt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdpt_pkg: shared types and constants for the trial division prime test
// Widths, wheel constants and the structs that pass between the sequencer,
// the serial remainder unit and the top level.
// ----------------------------------------------------------------------------
package tdpt_pkg;

  localparam int CAND_W = 32;          // candidate width
  localparam int DIV_W  = 16;          // trial divisors stay below 2^16
  localparam int SQ_W   = 32;          // running square of the trial divisor
  localparam int CNT_W  = $clog2(CAND_W);

  localparam logic [DIV_W-1:0] FIRST_ODD_DIV = DIV_W'(3);
  localparam logic [DIV_W-1:0] WHEEL_START   = DIV_W'(5);
  localparam logic [DIV_W-1:0] WHEEL_PAIR    = DIV_W'(2);
  localparam logic [DIV_W-1:0] WHEEL_STEP    = DIV_W'(6);
  localparam logic [SQ_W-1:0]  WHEEL_SQ0     = SQ_W'(25);
  localparam logic [SQ_W-1:0]  SQ_STEP_CONST = SQ_W'(36);   // 6*6
  localparam logic [CAND_W-1:0] SMALL_PRIME_MAX = CAND_W'(3);
  localparam logic [CAND_W-1:0] NOT_PRIME_MAX   = CAND_W'(1);

  // Request into the remainder unit
  typedef struct packed {
    logic              start;
    logic [CAND_W-1:0] dividend;
    logic [DIV_W-1:0]  divisor;
  } rem_req_t;

  // Response from the remainder unit
  typedef struct packed {
    logic done;
    logic zero;
  } rem_rsp_t;

  // Status from the sequencer to the top level
  typedef struct packed {
    logic busy;
    logic done;
    logic result;
  } seq_stat_t;

endpackage

/* rtl/tdpt_rem_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdpt_rem_unit: bit-serial restoring remainder
// Shifts the dividend in one bit per cycle and, once every bit is in, reports
// whether the remainder is zero.
// ----------------------------------------------------------------------------
module tdpt_rem_unit (
  input  logic              clk,
  input  logic              rst,
  input  tdpt_pkg::rem_req_t req,
  output tdpt_pkg::rem_rsp_t rsp
);
  import tdpt_pkg::*;

  logic              busy;
  logic [CNT_W-1:0]  cnt;
  logic [CAND_W-1:0] quo_sr;
  logic [DIV_W-1:0]  rem;
  logic [DIV_W-1:0]  div;
  logic [DIV_W:0]    trial;
  logic [DIV_W:0]    diff;
  logic [DIV_W-1:0]  rem_next;
  logic              last;

  assign trial = {rem, quo_sr[CAND_W-1]};
  assign diff  = trial - {1'b0, div};
  assign rem_next = diff[DIV_W] ? trial[DIV_W-1:0] : diff[DIV_W-1:0];
  assign last  = (cnt == CNT_W'(CAND_W - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      cnt      <= '0;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      if (req.start) begin
        busy   <= 1'b1;
        cnt    <= '0;
        quo_sr <= req.dividend;
        rem    <= '0;
        div    <= req.divisor;
      end else if (busy) begin
        rem    <= rem_next;
        quo_sr <= {quo_sr[CAND_W-2:0], 1'b0};
        cnt    <= cnt + CNT_W'(1);
        if (last) begin
          busy     <= 1'b0;
          rsp.done <= 1'b1;
          rsp.zero <= (rem_next == '0);
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_done_ends_busy: assert property (@(posedge clk) disable iff (rst)
    rsp.done |-> !busy) else $error("remainder done while still busy");
  a_no_start_busy: assert property (@(posedge clk) disable iff (rst)
    req.start |-> !busy) else $error("remainder start while busy");
  a_busy_holds: assert property (@(posedge clk) disable iff (rst)
    (busy && !last) |=> busy) else $error("remainder dropped busy early");
`endif

endmodule

/* rtl/tdpt_seq.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdpt_seq: trial division sequencer
// Classifies the candidate and, unless that settles it, tests 3 and then walks
// the 6k +/- 1 wheel, issuing one remainder per trial divisor and tracking the square of the divisor.
// ----------------------------------------------------------------------------
module tdpt_seq (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [tdpt_pkg::CAND_W-1:0] candidate,
  input  logic                      out_free,
  input  tdpt_pkg::rem_rsp_t        rsp,
  output tdpt_pkg::rem_req_t        req,
  output tdpt_pkg::seq_stat_t       stat
);
  import tdpt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_CLASSIFY, S_WAIT3, S_TEST, S_WAITA, S_WAITB, S_FINISH
  } state_t;

  state_t           state;
  logic [CAND_W-1:0] n;
  logic [DIV_W-1:0]  d;
  logic [SQ_W-1:0]   sq;
  logic [SQ_W-1:0]   sq_next;
  logic              result;
  logic              rem_start;
  logic [DIV_W-1:0]  rem_div;

  // (d+6)^2 = d^2 + 12d + 36
  assign sq_next = sq + (SQ_W'(d) << 3) + (SQ_W'(d) << 2) + SQ_STEP_CONST;

  assign req.start    = rem_start;
  assign req.divisor  = rem_div;
  assign req.dividend = n;
  assign stat.busy    = (state != S_IDLE);
  assign stat.done    = (state == S_FINISH) && out_free;
  assign stat.result  = result;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rem_start <= 1'b0;
    end else begin
      rem_start <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            n     <= candidate;
            state <= S_CLASSIFY;
          end
        end
        S_CLASSIFY: begin
          priority if (n[CAND_W-1] || n <= NOT_PRIME_MAX) begin
            result <= 1'b0;
            state  <= S_FINISH;
          end else if (n <= SMALL_PRIME_MAX) begin
            result <= 1'b1;
            state  <= S_FINISH;
          end else if (!n[0]) begin
            result <= 1'b0;
            state  <= S_FINISH;
          end else begin
            rem_start <= 1'b1;
            rem_div   <= FIRST_ODD_DIV;
            state     <= S_WAIT3;
          end
        end
        S_WAIT3: begin
          if (rsp.done) begin
            if (rsp.zero) begin
              result <= 1'b0;
              state  <= S_FINISH;
            end else begin
              d     <= WHEEL_START;
              sq    <= WHEEL_SQ0;
              state <= S_TEST;
            end
          end
        end
        S_TEST: begin
          if (sq > n) begin
            result <= 1'b1;
            state  <= S_FINISH;
          end else begin
            rem_start <= 1'b1;
            rem_div   <= d;
            state     <= S_WAITA;
          end
        end
        S_WAITA: begin
          if (rsp.done) begin
            if (rsp.zero) begin
              result <= 1'b0;
              state  <= S_FINISH;
            end else begin
              rem_start <= 1'b1;
              rem_div   <= d + WHEEL_PAIR;
              state     <= S_WAITB;
            end
          end
        end
        S_WAITB: begin
          if (rsp.done) begin
            if (rsp.zero) begin
              result <= 1'b0;
              state  <= S_FINISH;
            end else begin
              sq    <= sq_next;
              d     <= d + WHEEL_STEP;
              state <= S_TEST;
            end
          end
        end
        S_FINISH: begin
          if (out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_divisor_nonzero: assert property (@(posedge clk) disable iff (rst)
    req.start |-> (req.divisor != '0)) else $error("zero trial divisor");
  a_start_in_wait: assert property (@(posedge clk) disable iff (rst)
    req.start |-> (state == S_WAIT3 || state == S_WAITA || state == S_WAITB))
    else $error("remainder issued outside a wait state");
  a_done_to_idle: assert property (@(posedge clk) disable iff (rst)
    stat.done |=> (state == S_IDLE)) else $error("sequencer did not return idle");
`endif

endmodule

/* rtl/trial_division_prime_test_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trial_division_prime_test_top: primality test by 6k +/- 1 trial division
// Takes one signed 32-bit candidate per request and returns one is_prime bit.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: candidate with in_valid / in_stall. A request is taken
//   when in_valid is high and in_stall low. in_stall stays high from the
//   cycle after a request until its answer moves into the output register.
//   Output channel: is_prime with out_valid / out_stall; the answer holds in
//   the output register until the receiver takes it, so the next request
//   can be taken while an answer still waits.
//   Negatives, 0..3 and even values are answered from the classify step.
//   Odd values need the divide-by-3 check plus one wheel step, made of
//   two serial remainders with issue and test overhead, for each k with
//   (6k-1)^2 <= candidate. The worst case (large primes near 2^31) is
//   about 7700 steps; the single bit-serial remainder unit sets its pace.
//   Reset (rst, synchronous): drop any work in flight, clear out_valid.
//   A stalled receiver holds the answer; once the sequencer finishes the
//   next answer it waits until the output register is free.
// ----------------------------------------------------------------------------
module trial_division_prime_test_top (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [tdpt_pkg::CAND_W-1:0]  candidate,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         is_prime
);
  import tdpt_pkg::*;

  rem_req_t  req;
  rem_rsp_t  rsp;
  seq_stat_t stat;
  logic      in_accept;
  logic      out_free;

  // Hold off new requests while the sequencer owns a candidate
  assign in_stall  = stat.busy;
  assign in_accept = in_valid && !in_stall;

  // Output register is free when empty or being taken this cycle
  assign out_free = !out_valid || !out_stall;

  tdpt_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .start     (in_accept),
    .candidate (candidate),
    .out_free  (out_free),
    .rsp       (rsp),
    .req       (req),
    .stat      (stat)
  );

  tdpt_rem_unit u_rem (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  // Output register: load a finished answer, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (stat.done) begin
      out_valid <= 1'b1;
      is_prime  <= stat.result;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_accept_blocks: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> in_stall) else $error("request taken while one is in work");
  a_done_loads_out: assert property (@(posedge clk) disable iff (rst)
    stat.done |=> (out_valid && is_prime == $past(stat.result)))
    else $error("answer not loaded into output register");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    stat.done |-> !(out_valid && out_stall))
    else $error("answer overwrote a stalled result");
`endif

endmodule

/* dv/trial_division_prime_test_top_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trial_division_prime_test_top_test: self-checking bench for the prime test
// Drives candidates through the valid/stall request channel and checks each
// is_prime answer, in order, against a local trial-division predictor. The
// run covers sign and boundary corners, the wheel edges (exact squares,
// products of wheel divisors), one full-length worst case near 2^31, random
// small and wide values, a drain pause and a back-to-back stretch, with
// random idle cycles on both the request and the answer side.
// ----------------------------------------------------------------------------
module trial_division_prime_test_top_test;
  import tdpt_pkg::*;

  // Allow a few times the slowest correct run: one worst-case prime near
  // 2^31 plus about a hundred small and medium candidates.
  localparam int CYCLE_LIMIT = 4_000_000;
  localparam int MAX_IDLE    = 17;
  localparam int SETTLE      = 20;

  typedef struct {
    logic [CAND_W-1:0] candidate;
    logic              is_prime;
  } verdict_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [CAND_W-1:0] candidate = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              is_prime;

  verdict_t pending_verdicts[$];
  int       error_count = 0;
  int       cycle_count = 0;
  int       answer_hold = 0;
  bit       no_idle = 1'b0;

  trial_division_prime_test_top uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .candidate (candidate),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .is_prime  (is_prime)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Abort the run if the block stops answering.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Predict primality by 6k +/- 1 trial division. Form the square in 64 bits
  // so the loop bound stays exact for candidates just below 2^31.
  function automatic logic predict_prime(input logic [CAND_W-1:0] value);
    logic [31:0]     d;
    longint unsigned sq;
    if (value[CAND_W-1]) return 1'b0;        // negative, never prime
    if (value <= 32'd1) return 1'b0;
    if (value <= 32'd3) return 1'b1;
    if ((value % 32'd2) == 0 || (value % 32'd3) == 0) return 1'b0;
    d  = 32'd5;
    sq = 64'd25;
    while (sq <= longint'(value)) begin
      if ((value % d) == 0 || (value % (d + 32'd2)) == 0) return 1'b0;
      d  = d + 32'd6;
      sq = longint'(d) * longint'(d);
    end
    return 1'b1;
  endfunction

  function automatic int draw_idle();
    return no_idle ? 0 : $urandom_range(0, MAX_IDLE);
  endfunction

  // Send one candidate request. Drop valid only for an idle gap, so a
  // back-to-back request never sees valid lowered and raised in one step.
  task automatic send_candidate(input logic [CAND_W-1:0] value);
    int gap;
    gap = draw_idle();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    candidate <= value;
    // Hold the request until an edge sees it with stall low.
    do @(posedge clk); while (in_stall);
    pending_verdicts.push_back('{candidate: value, is_prime: predict_prime(value)});
  endtask

  // Hold off new requests until every pending answer has come back.
  task automatic wait_for_answers();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_verdicts.size() != 0) @(posedge clk);
  endtask

  // Answer side: check each accepted answer against the oldest prediction,
  // then draw how long to stall before taking the next one.
  always @(posedge clk) begin
    verdict_t want;
    int       hold;
    hold = answer_hold;
    if (!rst && out_valid && !out_stall) begin
      if (pending_verdicts.size() == 0) begin
        $display("%0t: unexpected answer: expected none, actual is_prime=%0b",
                 $time, is_prime);
        error_count++;
      end else begin
        want = pending_verdicts.pop_front();
        if (is_prime !== want.is_prime) begin
          $display("%0t: candidate %0d: expected is_prime=%0b, actual is_prime=%0b",
                   $time, $signed(want.candidate), want.is_prime, is_prime);
          error_count++;
        end
      end
      hold = draw_idle();
    end else if (hold != 0) begin
      hold = hold - 1;
    end
    answer_hold <= hold;
    out_stall   <= (hold != 0);
  end

  // Corners: sign bit, 0..4, exact squares at the loop bound, products of
  // wheel divisors, small primes and the largest positive value (prime).
  task automatic test_corner_values();
    logic [CAND_W-1:0] corner_values [24];
    corner_values = '{
      32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFF9, 32'd0, 32'd1, 32'd2,
      32'd3, 32'd4, 32'd9, 32'd25, 32'd35, 32'd49, 32'd121, 32'd143,
      32'd169, 32'd5, 32'd7, 32'd11, 32'd13, 32'd97, 32'd1000003,
      32'd2147483646, 32'd2147483645, 32'd2147483647
    };
    foreach (corner_values[i]) send_candidate(corner_values[i]);
  endtask

  // Small values keep each test short while walking the wheel many steps.
  task automatic test_random_small(input int count);
    repeat (count) send_candidate(CAND_W'($urandom_range(0, 65535)));
  endtask

  // Stop feeding, let the block drain, then resume.
  task automatic test_drain_pause();
    repeat (4) send_candidate(CAND_W'($urandom_range(0, 4095)));
    wait_for_answers();
    repeat (4) send_candidate(CAND_W'($urandom_range(0, 4095)));
  endtask

  // Back-to-back requests and answers with no idle cycles.
  task automatic test_back_to_back();
    no_idle = 1'b1;
    test_random_small(15);
    no_idle = 1'b0;
  endtask

  // Full-width values: negatives, evens and multiples of five answer fast
  // and exercise every bit; a share of mid-size values runs longer loops.
  task automatic test_random_wide(input int count);
    logic [CAND_W-1:0] value;
    repeat (count) begin
      case ($urandom_range(0, 3))
        0: value = $urandom() | 32'h8000_0000;
        1: value = $urandom() & ~32'h1;
        2: begin
          value = $urandom() & 32'h7FFF_FFFF;
          value = value - (value % 32'd5);
        end
        default: value = CAND_W'($urandom_range(65536, 1048575));
      endcase
      send_candidate(value);
    end
  endtask

  initial begin
    // Hold reset, then release it once.
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_corner_values();
    test_random_small(30);
    test_drain_pause();
    test_back_to_back();
    test_random_wide(30);

    // Drain and let the block settle before the verdict.
    wait_for_answers();
    repeat (SETTLE) @(posedge clk);
    if (error_count == 0 && pending_verdicts.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/tdpt_pkg.sv
rtl/tdpt_rem_unit.sv
rtl/tdpt_seq.sv
rtl/trial_division_prime_test_top.sv
dv/trial_division_prime_test_top_test.sv
